FILE: rtl/core/cfr_pkg.sv
package cfr_pkg;

    localparam int CFR_CHANNELS = 3;
    localparam int CFR_OUT_FRAC = 15;
    localparam int CFR_OUT_W    = CFR_OUT_FRAC + 1;
    localparam int CFR_IN_W     = 16;
    localparam int CFR_FB       = 22;
    localparam int CFR_Q_W      = 31;   // Q.30 ratio, 0 .. 1.0
    localparam int CFR_DIV_W    = 33;   // normalized denominator width

    localparam logic [CFR_IN_W-1:0] COS_ONE = 16'd32768;

    typedef struct packed {
        logic [CFR_IN_W-1:0] n_red;
        logic [CFR_IN_W-1:0] n_green;
        logic [CFR_IN_W-1:0] n_blue;
        logic [CFR_IN_W-1:0] k_red;
        logic [CFR_IN_W-1:0] k_green;
        logic [CFR_IN_W-1:0] k_blue;
        logic [CFR_IN_W-1:0] cos_theta;
    } t_in_word;

    typedef struct packed {
        logic [CFR_OUT_W-1:0] refl_red;
        logic [CFR_OUT_W-1:0] refl_green;
        logic [CFR_OUT_W-1:0] refl_blue;
    } t_out_word;

endpackage

FILE: rtl/core/cfr_isqrt.sv
module cfr_isqrt import cfr_pkg::*; #(
    parameter int IN_W = 64,
    parameter int SB_W = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [IN_W-1:0]     i_rad,
    input  logic [SB_W-1:0]     i_sb,
    output logic                o_valid,
    output logic [IN_W/2-1:0]   o_root,
    output logic [SB_W-1:0]     o_sb
);

    localparam int OUT_W = IN_W / 2;
    localparam int RW    = OUT_W + 2;

    logic              r_vld  [OUT_W];
    logic [RW-1:0]     r_rem  [OUT_W];
    logic [OUT_W-1:0]  r_root [OUT_W];
    logic [IN_W-1:0]   r_rad  [OUT_W];
    logic [SB_W-1:0]   r_sb   [OUT_W];

    // one result bit per stage, radicand consumed two bits at a time from the top
    for (genvar g = 0; g < OUT_W; g++) begin : g_step
        logic              p_vld;
        logic [RW-1:0]     p_rem;
        logic [OUT_W-1:0]  p_root;
        logic [IN_W-1:0]   p_rad;
        logic [SB_W-1:0]   p_sb;
        logic [RW-1:0]     n_sh;
        logic [RW-1:0]     n_trial;
        logic              n_ge;

        if (g == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
            assign p_sb   = i_sb;
        end else begin : g_next
            assign p_vld  = r_vld[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
            assign p_rad  = r_rad[g-1];
            assign p_sb   = r_sb[g-1];
        end

        assign n_sh    = {p_rem[RW-3:0], p_rad[IN_W-1 -: 2]};
        assign n_trial = {p_root, 2'b01};
        assign n_ge    = (n_sh >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_ge ? (n_sh - n_trial) : n_sh;
                r_root[g] <= {p_root[OUT_W-2:0], n_ge};
                r_rad[g]  <= {p_rad[IN_W-3:0], 2'b00};
                r_sb[g]   <= p_sb;
            end
        end
    end

    assign o_valid = r_vld[OUT_W-1];
    assign o_root  = r_root[OUT_W-1];
    assign o_sb    = r_sb[OUT_W-1];

endmodule

FILE: rtl/core/cfr_ratio.sv
module cfr_ratio import cfr_pkg::*; #(
    parameter int DEN_W = 56,
    parameter int SB_W  = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [DEN_W-1:0]    i_num,
    input  logic [DEN_W-1:0]    i_den,
    input  logic [SB_W-1:0]     i_sb,
    output logic                o_valid,
    output logic [CFR_Q_W-1:0]  o_q,
    output logic [SB_W-1:0]     o_sb
);

    localparam int SH_W = $clog2(DEN_W - CFR_DIV_W + 2);

    // normalize: drop low bits of both until the denominator fits 33 bits
    logic [SH_W-1:0]       n_sh;
    logic [DEN_W-1:0]      n_num_s;
    logic [DEN_W-1:0]      n_den_s;
    logic [CFR_DIV_W-1:0]  n_num;
    logic [CFR_DIV_W-1:0]  n_den;

    always_comb begin
        n_sh = '0;
        for (int i = CFR_DIV_W; i < DEN_W; i++) begin
            if (i_den[i]) begin
                n_sh = SH_W'(i - CFR_DIV_W + 1);
            end
        end
        n_num_s = i_num >> n_sh;
        n_den_s = i_den >> n_sh;
        n_den   = n_den_s[CFR_DIV_W-1:0];
        n_num   = (n_num_s[CFR_DIV_W-1:0] > n_den) ? n_den : n_num_s[CFR_DIV_W-1:0];
    end

    logic                  r_n_vld;
    logic [CFR_DIV_W-1:0]  r_n_num;
    logic [CFR_DIV_W-1:0]  r_n_den;
    logic [SB_W-1:0]       r_n_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_vld <= 1'b0;
        end else if (i_en) begin
            r_n_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n_num <= n_num;
            r_n_den <= n_den;
            r_n_sb  <= i_sb;
        end
    end

    // restoring divide, one quotient bit per stage; num <= den so the top bit is 1.0
    logic                  r_vl  [CFR_Q_W];
    logic [CFR_DIV_W-1:0]  r_rem [CFR_Q_W];
    logic [CFR_DIV_W-1:0]  r_dv  [CFR_Q_W];
    logic [CFR_Q_W-1:0]    r_q   [CFR_Q_W];
    logic [SB_W-1:0]       r_sbs [CFR_Q_W];

    for (genvar g = 0; g < CFR_Q_W; g++) begin : g_div
        logic                  p_vl;
        logic [CFR_DIV_W-1:0]  p_rem;
        logic [CFR_DIV_W-1:0]  p_dv;
        logic [CFR_Q_W-1:0]    p_q;
        logic [SB_W-1:0]       p_sb;
        logic [CFR_DIV_W:0]    n_r;
        logic [CFR_DIV_W:0]    n_diff;
        logic                  n_ge;

        if (g == 0) begin : g_first
            assign p_vl  = r_n_vld;
            assign p_rem = r_n_num;
            assign p_dv  = r_n_den;
            assign p_q   = '0;
            assign p_sb  = r_n_sb;
            assign n_r   = {1'b0, p_rem};
        end else begin : g_next
            assign p_vl  = r_vl[g-1];
            assign p_rem = r_rem[g-1];
            assign p_dv  = r_dv[g-1];
            assign p_q   = r_q[g-1];
            assign p_sb  = r_sbs[g-1];
            assign n_r   = {p_rem, 1'b0};
        end

        assign n_ge   = (n_r >= {1'b0, p_dv});
        assign n_diff = n_r - {1'b0, p_dv};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vl[g] <= 1'b0;
            end else if (i_en) begin
                r_vl[g] <= p_vl;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_ge ? n_diff[CFR_DIV_W-1:0] : n_r[CFR_DIV_W-1:0];
                r_dv[g]  <= p_dv;
                r_q[g]   <= {p_q[CFR_Q_W-2:0], n_ge};
                r_sbs[g] <= p_sb;
            end
        end
    end

    assign o_valid = r_vl[CFR_Q_W-1];
    assign o_q     = r_q[CFR_Q_W-1];
    assign o_sb    = r_sbs[CFR_Q_W-1];

endmodule

FILE: rtl/core/cfr_channel.sv
module cfr_channel import cfr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [CFR_IN_W-1:0]   i_n,
    input  logic [CFR_IN_W-1:0]   i_k,
    input  logic [CFR_IN_W-1:0]   i_c,
    output logic                  o_valid,
    output logic [CFR_OUT_W-1:0]  o_refl
);

    typedef struct packed {
        logic        neg;
        logic [30:0] at0;
        logic [22:0] c2;
        logic [22:0] s2;
        logic [15:0] c;
    } t_geo;

    typedef struct packed {
        logic [32:0] t1;
        logic [31:0] ab;
        logic [22:0] c2;
        logic [22:0] s2;
        logic [15:0] c;
    } t_mid;

    // stage 1: squares
    logic [CFR_IN_W-1:0] n_c;
    logic [31:0]         n_nn;
    logic [31:0]         n_kk;
    logic [31:0]         n_cc;
    logic                r1_vld;
    logic [29:0]         r1_n2;
    logic [29:0]         r1_k2;
    logic [22:0]         r1_c2;
    logic [15:0]         r1_c;

    assign n_c  = (i_c > COS_ONE) ? COS_ONE : i_c;
    assign n_nn = 32'(i_n) * 32'(i_n);
    assign n_kk = 32'(i_k) * 32'(i_k);
    assign n_cc = 32'(n_c) * 32'(n_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_n2 <= n_nn[31:2];
            r1_k2 <= n_kk[31:2];
            r1_c2 <= n_cc[30:8];
            r1_c  <= n_c;
        end
    end

    // stage 2: t0 and n2*k2
    logic [22:0] n_s2;
    logic [31:0] n_t0;
    logic [31:0] n_t0_neg;
    logic        r2_vld;
    t_geo        r2_geo;
    logic [59:0] r2_nk;

    assign n_s2     = 23'h400000 - r1_c2;
    assign n_t0     = {2'b00, r1_n2} - {2'b00, r1_k2} - {9'd0, n_s2};
    assign n_t0_neg = 32'd0 - n_t0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_geo.neg <= n_t0[31];
            r2_geo.at0 <= n_t0[31] ? n_t0_neg[30:0] : n_t0[30:0];
            r2_geo.c2  <= r1_c2;
            r2_geo.s2  <= n_s2;
            r2_geo.c   <= r1_c;
            r2_nk      <= 60'(r1_n2) * 60'(r1_k2);
        end
    end

    // stage 3: t0^2, stage 4: radicand
    logic        r3_vld;
    t_geo        r3_geo;
    logic [61:0] r3_sq;
    logic [59:0] r3_nk;
    logic        r4_vld;
    t_geo        r4_geo;
    logic [63:0] r4_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_sq  <= 62'(r2_geo.at0) * 62'(r2_geo.at0);
            r3_nk  <= r2_nk;
            r3_geo <= r2_geo;
            r4_rad <= 64'(r3_sq) + {2'b00, r3_nk, 2'b00};
            r4_geo <= r3_geo;
        end
    end

    logic        s1_vld;
    logic [31:0] s1_ab;
    t_geo        s1_geo;

    cfr_isqrt #(.IN_W(64), .SB_W($bits(t_geo))) u_sqrt_ab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r4_vld),
        .i_rad   (r4_rad),
        .i_sb    (r4_geo),
        .o_valid (s1_vld),
        .o_root  (s1_ab),
        .o_sb    (s1_geo)
    );

    // stage 5: half and t1
    logic [32:0] n_hs;
    logic        r5_vld;
    logic [53:0] r5_rad;
    t_mid        r5_mid;

    assign n_hs = s1_geo.neg ? (33'(s1_ab) - 33'(s1_geo.at0))
                             : (33'(s1_ab) + 33'(s1_geo.at0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r5_vld <= s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_rad    <= {n_hs[32:1], 22'd0};
            r5_mid.t1 <= 33'(s1_ab) + 33'(s1_geo.c2);
            r5_mid.ab <= s1_ab;
            r5_mid.c2 <= s1_geo.c2;
            r5_mid.s2 <= s1_geo.s2;
            r5_mid.c  <= s1_geo.c;
        end
    end

    logic        s2_vld;
    logic [26:0] s2_a;
    t_mid        s2_mid;

    cfr_isqrt #(.IN_W(54), .SB_W($bits(t_mid))) u_sqrt_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r5_vld),
        .i_rad   (r5_rad),
        .i_sb    (r5_mid),
        .o_valid (s2_vld),
        .o_root  (s2_a),
        .o_sb    (s2_mid)
    );

    // stage 6: t2 = a*cos >> 14
    logic [42:0] n_ac;
    logic        r6_vld;
    logic [28:0] r6_t2;
    t_mid        r6_mid;

    assign n_ac = 43'(s2_a) * 43'(s2_mid.c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (i_en) begin
            r6_vld <= s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_t2  <= n_ac[42:14];
            r6_mid <= s2_mid;
        end
    end

    // stage 7: s term operands, p term products
    logic        r7_vld;
    logic [33:0] r7_den1;
    logic [33:0] r7_num1;
    logic [54:0] r7_ca;
    logic [45:0] r7_ss;
    logic [51:0] r7_t4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (i_en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_den1 <= 34'(r6_mid.t1) + 34'(r6_t2);
            r7_num1 <= (r6_mid.t1 > 33'(r6_t2)) ? (34'(r6_mid.t1) - 34'(r6_t2)) : 34'd0;
            r7_ca   <= 55'(r6_mid.c2) * 55'(r6_mid.ab);
            r7_ss   <= 46'(r6_mid.s2) * 46'(r6_mid.s2);
            r7_t4   <= 52'(r6_t2) * 52'(r6_mid.s2);
        end
    end

    // stage 8: p term sums, zero checks
    logic [55:0] n_t3;
    logic        r8_vld;
    logic [33:0] r8_den1;
    logic [33:0] r8_num1;
    logic [55:0] r8_den2;
    logic [55:0] r8_num2;
    logic        r8_zero1;
    logic        r8_zero2;

    assign n_t3 = 56'(r7_ca) + 56'(r7_ss);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (i_en) begin
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r8_den1  <= r7_den1;
            r8_num1  <= r7_num1;
            r8_zero1 <= (r7_den1 == 34'd0);
            r8_den2  <= n_t3 + 56'(r7_t4);
            r8_num2  <= (n_t3 > 56'(r7_t4)) ? (n_t3 - 56'(r7_t4)) : 56'd0;
            r8_zero2 <= ((n_t3 + 56'(r7_t4)) == 56'd0);
        end
    end

    logic               d1_vld;
    logic               d2_vld;
    logic [CFR_Q_W-1:0] d1_rs;
    logic [CFR_Q_W-1:0] d2_q;
    logic               d1_zero;
    logic               d2_zero;

    cfr_ratio #(.DEN_W(34), .SB_W(1)) u_ratio_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r8_vld),
        .i_num   (r8_num1),
        .i_den   (r8_den1),
        .i_sb    (r8_zero1),
        .o_valid (d1_vld),
        .o_q     (d1_rs),
        .o_sb    (d1_zero)
    );

    cfr_ratio #(.DEN_W(56), .SB_W(1)) u_ratio_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r8_vld),
        .i_num   (r8_num2),
        .i_den   (r8_den2),
        .i_sb    (r8_zero2),
        .o_valid (d2_vld),
        .o_q     (d2_q),
        .o_sb    (d2_zero)
    );

    // stage 9: rp = rs*q, stage 10: mean and saturate
    logic [61:0]        n_p;
    logic               r9_vld;
    logic [CFR_Q_W-1:0] r9_rs;
    logic [30:0]        r9_rp;
    logic               r9_zero;
    logic [31:0]        n_sum;
    logic [31:0]        n_fin;
    logic               r10_vld;
    logic [CFR_OUT_W-1:0] r10_out;

    assign n_p   = 62'(d1_rs) * 62'(d2_q);
    assign n_sum = 32'(r9_rs) + 32'(r9_rp);
    assign n_fin = (r9_zero || n_sum > 32'h8000_0000) ? 32'h8000_0000 : n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld  <= 1'b0;
            r10_vld <= 1'b0;
        end else if (i_en) begin
            r9_vld  <= d1_vld && d2_vld;
            r10_vld <= r9_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r9_rs   <= d1_rs;
            r9_rp   <= n_p[60:30];
            r9_zero <= d1_zero || d2_zero;
            r10_out <= n_fin[31 -: CFR_OUT_W];
        end
    end

    assign o_valid = r10_vld;
    assign o_refl  = r10_out;

endmodule

FILE: rtl/core/conductor_fresnel_reflectance.sv
// channel | dir | handshake                  | word
// --------+-----+----------------------------+------------------------
// in      | in  | i_in_valid / o_in_ready    | i_in_word  (t_in_word)
// out     | out | o_out_valid / i_out_ready  | o_out_word (t_out_word)
//
// One word enters per cycle while the output buffer has room; 101 pipeline stages, set by the
// 64-bit and 54-bit square roots (one root bit per stage) and the 31-stage dividers,
// feed the output buffer.
// A two-word output buffer lets the pipeline keep taking words while a
// result waits; the whole pipeline holds only when that buffer is full.
// Reset (i_rst_n low, synchronous) clears all valid bits and the buffer.
module conductor_fresnel_reflectance import cfr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic [CFR_IN_W-1:0]  w_n    [CFR_CHANNELS];
    logic [CFR_IN_W-1:0]  w_k    [CFR_CHANNELS];
    logic [CFR_OUT_W-1:0] w_refl [CFR_CHANNELS];
    logic [CFR_CHANNELS-1:0] w_vld;

    assign w_n[0] = i_in_word.n_red;
    assign w_n[1] = i_in_word.n_green;
    assign w_n[2] = i_in_word.n_blue;
    assign w_k[0] = i_in_word.k_red;
    assign w_k[1] = i_in_word.k_green;
    assign w_k[2] = i_in_word.k_blue;

    logic w_en;
    logic w_push;
    logic w_pop;

    for (genvar g = 0; g < CFR_CHANNELS; g++) begin : g_ch
        cfr_channel u_ch (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (i_in_valid),
            .i_n     (w_n[g]),
            .i_k     (w_k[g]),
            .i_c     (i_in_word.cos_theta),
            .o_valid (w_vld[g]),
            .o_refl  (w_refl[g])
        );
    end

    // output buffer, two words
    t_out_word  r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    t_out_word  w_word;

    assign w_word.refl_red   = w_refl[0];
    assign w_word.refl_green = w_refl[1];
    assign w_word.refl_blue  = w_refl[2];

    assign w_en        = (r_cnt != 2'd2);
    assign w_push      = w_en && w_vld[0];
    assign w_pop       = o_out_valid && i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_word  = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr_ptr] <= w_word;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld == {CFR_CHANNELS{1'b0}} || w_vld == {CFR_CHANNELS{1'b1}})
        else $error("channel pipelines out of step");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_out_ready) |=> (r_cnt == 2'd2))
        else $error("buffer lost a word while stalled");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.refl_red <= 16'd32768 &&
                         o_out_word.refl_green <= 16'd32768 &&
                         o_out_word.refl_blue <= 16'd32768))
        else $error("reflectance above 1.0");

endmodule

FILE: verif/tb_top.sv
module tb_top;
    import cfr_pkg::*;

    localparam int LATENCY = 102;
    localparam int RANDOM_WORDS = 750;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    t_out_word refl_queue[$];
    int        mismatches = 0;
    int        words_in = 0;
    int        words_out = 0;
    bit        stim_done = 1'b0;
    bit        long_hold = 1'b0;

    conductor_fresnel_reflectance dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] frac_q30(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        while (den >= (64'd1 << 33)) begin
            den = den >> 1;
            num = num >> 1;
        end
        if (den == 0) return 64'd1 << 30;
        if (num > den) num = den;
        q = (num << 30) / den;
        return (q > (64'd1 << 30)) ? (64'd1 << 30) : q;
    endfunction

    // reflectance sum rs + rp in Q.31 scale (2^31 means 1.0)
    function automatic logic [63:0] conductor_refl(input logic [63:0] n, input logic [63:0] k,
                                                   input logic [63:0] c);
        logic [63:0] n2, k2, c2, s2, at0, ab, half, a, t1, t2, t3, t4, rs, q, rp, sum;
        logic signed [63:0] t0;
        n2 = (n * n) >> 2;
        k2 = (k * k) >> 2;
        c2 = (c * c) >> 8;
        s2 = (64'd1 << 22) - c2;
        t0 = $signed(n2) - $signed(k2) - $signed(s2);
        at0 = (t0 < 0) ? -t0 : t0;
        ab = isqrt(at0 * at0 + 64'd4 * n2 * k2);
        half = (t0 < 0) ? (ab - at0) >> 1 : (ab + at0) >> 1;
        a = isqrt(half << 22);
        t1 = ab + c2;
        t2 = (a * c) >> 14;
        if (t1 + t2 == 0) return 64'd1 << 31;
        rs = frac_q30((t1 > t2) ? t1 - t2 : 64'd0, t1 + t2);
        t3 = c2 * ab + s2 * s2;
        t4 = t2 * s2;
        if (t3 + t4 == 0) return 64'd1 << 31;
        q = frac_q30((t3 > t4) ? t3 - t4 : 64'd0, t3 + t4);
        rp = (rs * q) >> 30;
        sum = rs + rp;
        return (sum > (64'd1 << 31)) ? (64'd1 << 31) : sum;
    endfunction

    function automatic t_out_word predict_refl(input t_in_word w);
        t_out_word r;
        logic [63:0] c;
        c = 64'(w.cos_theta);
        if (c > 64'(COS_ONE)) c = 64'(COS_ONE);
        r.refl_red   = CFR_OUT_W'(conductor_refl(64'(w.n_red), 64'(w.k_red), c)
                                  >> (31 - CFR_OUT_FRAC));
        r.refl_green = CFR_OUT_W'(conductor_refl(64'(w.n_green), 64'(w.k_green), c)
                                  >> (31 - CFR_OUT_FRAC));
        r.refl_blue  = CFR_OUT_W'(conductor_refl(64'(w.n_blue), 64'(w.k_blue), c)
                                  >> (31 - CFR_OUT_FRAC));
        return r;
    endfunction

    task automatic send_word(input t_in_word w);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        words_in++;
    endtask

    task automatic drop_valid();
        i_in_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] rnd_metal();
        return 16'($urandom_range(0, 32767));
    endfunction

    function automatic t_in_word rand_word();
        t_in_word w;
        int       mode;
        mode = int'($urandom_range(0, 9));
        w.n_red   = rnd16(); w.n_green = rnd16(); w.n_blue = rnd16();
        w.k_red   = rnd16(); w.k_green = rnd16(); w.k_blue = rnd16();
        if (mode < 6) begin
            // realistic metals: n, k within 0 .. 8
            w.n_red   = rnd_metal(); w.k_red   = rnd_metal();
            w.n_green = rnd_metal(); w.k_green = rnd_metal();
            w.n_blue  = rnd_metal(); w.k_blue  = rnd_metal();
        end
        if (mode < 8) w.cos_theta = 16'($urandom_range(0, 32768));
        else w.cos_theta = rnd16();
        return w;
    endfunction

    // directed table: word and, where obvious, the expected word
    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word r;
    } t_row;

    t_row rows[$];

    task automatic add_row(input logic [15:0] n, input logic [15:0] k, input logic [15:0] c,
                           input bit typed, input logic [15:0] r);
        t_row row;
        row.w = '{n, n, n, k, k, k, c};
        row.typed = typed;
        row.r = '{r, r, r};
        rows.push_back(row);
    endtask

    initial begin
        t_in_word w;
        t_row     row;
        int       burst;
        // zero indices at grazing reflect fully
        add_row(16'd0, 16'd0, 16'd0, 1'b1, 16'h8000);
        add_row(16'd0, 16'd0, 16'd32768, 1'b0, 16'd0);
        add_row(16'd4096, 16'd0, 16'd32768, 1'b1, 16'd0);   // index match, no reflection
        add_row(16'd4096, 16'd0, 16'd0, 1'b0, 16'd0);
        add_row(16'hFFFF, 16'hFFFF, 16'd32768, 1'b0, 16'd0);
        add_row(16'hFFFF, 16'hFFFF, 16'd0, 1'b0, 16'd0);
        add_row(16'hFFFF, 16'd0, 16'd16384, 1'b0, 16'd0);
        add_row(16'd0, 16'hFFFF, 16'd16384, 1'b0, 16'd0);
        add_row(16'd0, 16'd0, 16'hFFFF, 1'b0, 16'd0);       // cosine above one
        add_row(16'd1234, 16'd5678, 16'd40000, 1'b0, 16'd0);
        add_row(16'd1, 16'd1, 16'd1, 1'b0, 16'd0);
        add_row(16'hAAAA, 16'h5555, 16'h5555, 1'b0, 16'd0);
        add_row(16'h5555, 16'hAAAA, 16'h2AAA, 1'b0, 16'd0);
        row.w = '{16'd700, 16'd3900, 16'd5200, 16'd12000, 16'd9000, 16'd600, 16'd20000};
        row.typed = 1'b0;
        rows.push_back(row);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            refl_queue.push_back(rows[i].typed ? rows[i].r : predict_refl(rows[i].w));
            send_word(rows[i].w);
        end
        drop_valid();

        for (int i = 0; i < RANDOM_WORDS;) begin
            burst = int'($urandom_range(1, 40));
            for (int b = 0; b < burst && i < RANDOM_WORDS; b++, i++) begin
                w = rand_word();
                refl_queue.push_back(predict_refl(w));
                send_word(w);
            end
            if ($urandom_range(0, 2) != 0) begin
                drop_valid();
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        drop_valid();
        stim_done = 1'b1;
    end

    // receiver: random stall pattern plus one long hold-off
    initial begin
        int mode;
        wait (i_rst_n);
        repeat (30) @(posedge i_clk);
        forever begin
            if (!long_hold && words_in > 200) begin
                long_hold = 1'b1;
                i_out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            mode = int'($urandom_range(0, 3));
            repeat ($urandom_range(5, 60)) begin
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 3) != 0);
                    2: i_out_ready <= ($urandom_range(0, 1) != 0);
                    default: i_out_ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            words_out++;
            if (refl_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", o_out_word);
            end else begin
                exp_w = refl_queue.pop_front();
                if (exp_w !== o_out_word) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at word %0d: expected r=%h g=%h b=%h got r=%h g=%h b=%h",
                                 words_out - 1, exp_w.refl_red, exp_w.refl_green,
                                 exp_w.refl_blue, o_out_word.refl_red,
                                 o_out_word.refl_green, o_out_word.refl_blue);
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        while (refl_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        $display("covered %0d words, %0d results, incl. grazing, normal, cosine above one",
                 words_in, words_out);
        $display("output held off once for 400 cycles under random input bursts");
        if (mismatches == 0 && refl_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("simulation failed");
        end
        $finish;
    end
endmodule

FILE: conductor_fresnel_reflectance.f
rtl/core/cfr_pkg.sv
rtl/core/cfr_isqrt.sv
rtl/core/cfr_ratio.sv
rtl/core/cfr_channel.sv
rtl/core/conductor_fresnel_reflectance.sv
verif/tb_top.sv
